// File: hw/rtl/lfsr_noise_sound_channel_core_macros.svh
// assertion macros for the noise channel core
`ifndef LFSR_NOISE_SOUND_CHANNEL_CORE_MACROS_SVH
`define LFSR_NOISE_SOUND_CHANNEL_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// condition must hold in the same cycle as the trigger
`define LNSC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// condition must hold in the cycle after the trigger
`define LNSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LNSC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define LNSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// File: hw/rtl/lnsc_pkg.sv
// shared types and constants for the noise channel core
package lnsc_pkg;

  // item kinds
  typedef enum logic [1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_NOISE  = 2'd2,
    FUNC_LENGTH = 2'd3
  } func_t;

  // register byte offsets
  localparam logic [2:0] REG_LENGTH   = 3'd0;
  localparam logic [2:0] REG_ENVELOPE = 3'd1;
  localparam logic [2:0] REG_POLY     = 3'd4;
  localparam logic [2:0] REG_CONTROL  = 3'd5;

  // lfsr feedback and seed patterns
  localparam logic [14:0] XOR_WIDE    = 15'h6000;
  localparam logic [14:0] XOR_NARROW  = 15'h0060;
  localparam logic [14:0] SEED_WIDE   = 15'h4000;
  localparam logic [14:0] SEED_NARROW = 15'h0040;

  localparam logic [6:0] LENGTH_FULL = 7'd64;
  localparam logic [7:0] LENGTH_EN_MASK = 8'h40;

  // one input item
  typedef struct packed {
    func_t       func;
    logic [2:0]  reg_offset;
    logic [7:0]  write_value;
  } item_t;

  // one result item
  typedef struct packed {
    logic [7:0]        read_data;
    logic signed [7:0] sample_out;
    logic              channel_on;
  } result_t;

endpackage

// File: hw/rtl/lnsc_state.sv
// channel state, register file, lfsr step and per-item result
`include "lfsr_noise_sound_channel_core_macros.svh"

module lnsc_state (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  lnsc_pkg::item_t  item,
  output lnsc_pkg::result_t res
);
  import lnsc_pkg::*;

  logic [14:0]       shift_reg, shift_reg_next;
  logic              narrow_mode, narrow_mode_next;
  logic [2:0]        freq_ratio, freq_ratio_next;
  logic [3:0]        freq_shift, freq_shift_next;
  logic              length_on, length_on_next;
  logic              dac_on, dac_on_next;
  logic              chan_enabled, chan_enabled_next;
  logic [6:0]        length_left, length_left_next;
  logic [2:0]        env_divider, env_divider_next;
  logic              env_increase, env_increase_next;
  logic [3:0]        env_initial, env_initial_next;
  logic [3:0]        env_volume, env_volume_next;
  logic              env_active, env_active_next;
  logic signed [7:0] last_sample, last_sample_next;
  logic [7:0]        read_data_next;

  logic [3:0]  zombie_vol;
  logic        new_inc;
  logic        out_bit;
  logic [14:0] shifted;
  logic [7:0]  mag;
  logic        restart_xfer;
  logic        restart_ok;

  // zombie-mode volume adjustment and lfsr shift, precomputed
  always_comb begin
    new_inc    = item.write_value[3];
    zombie_vol = env_volume;
    if (env_divider == 3'd0 && env_active) begin
      zombie_vol = env_volume + 4'd1;
    end else if (!env_increase) begin
      zombie_vol = env_volume + 4'd2;
    end
    if (env_increase != new_inc) begin
      zombie_vol = 4'd0 - zombie_vol;
    end
    out_bit = shift_reg[0];
    shifted = {1'b0, shift_reg[14:1]};
    if (out_bit) begin
      shifted = shifted ^ (narrow_mode ? XOR_NARROW : XOR_WIDE);
    end
    mag = {1'b0, env_volume, 3'b000};
  end

  // next state for one item
  always_comb begin
    shift_reg_next    = shift_reg;
    narrow_mode_next  = narrow_mode;
    freq_ratio_next   = freq_ratio;
    freq_shift_next   = freq_shift;
    length_on_next    = length_on;
    dac_on_next       = dac_on;
    chan_enabled_next = chan_enabled;
    length_left_next  = length_left;
    env_divider_next  = env_divider;
    env_increase_next = env_increase;
    env_initial_next  = env_initial;
    env_volume_next   = env_volume;
    env_active_next   = env_active;
    last_sample_next  = last_sample;
    read_data_next    = 8'd0;
    unique case (item.func)
      FUNC_WRITE: begin
        unique case (item.reg_offset)
          REG_LENGTH: begin
            length_left_next = LENGTH_FULL - {1'b0, item.write_value[5:0]};
          end
          REG_ENVELOPE: begin
            env_divider_next  = item.write_value[2:0];
            env_increase_next = new_inc;
            env_initial_next  = item.write_value[7:4];
            dac_on_next       = (item.write_value[7:3] != 5'd0);
            if (item.write_value[7:3] == 5'd0) begin
              chan_enabled_next = 1'b0;
            end
            env_volume_next = zombie_vol;
          end
          REG_POLY: begin
            freq_ratio_next  = item.write_value[2:0];
            narrow_mode_next = item.write_value[3];
            freq_shift_next  = item.write_value[7:4];
          end
          REG_CONTROL: begin
            length_on_next = item.write_value[6];
            // restart
            if (item.write_value[7]) begin
              if (dac_on) begin
                chan_enabled_next = 1'b1;
              end
              if (length_left == 7'd0) begin
                length_left_next = LENGTH_FULL;
              end
              env_volume_next = env_initial;
              env_active_next = 1'b1;
              shift_reg_next  = narrow_mode ? SEED_NARROW : SEED_WIDE;
            end
          end
          default: begin
          end
        endcase
      end
      FUNC_READ: begin
        unique case (item.reg_offset)
          REG_ENVELOPE: read_data_next = {env_initial, env_increase, env_divider};
          REG_POLY:     read_data_next = {freq_shift, narrow_mode, freq_ratio};
          REG_CONTROL:  read_data_next = length_on ? LENGTH_EN_MASK : 8'd0;
          default:      read_data_next = 8'd0;
        endcase
      end
      FUNC_NOISE: begin
        // expired length halts the lfsr and mutes
        if (length_on && length_left == 7'd0) begin
          chan_enabled_next = 1'b0;
          last_sample_next  = 8'sd0;
        end else begin
          shift_reg_next = shifted;
          if (!dac_on) begin
            last_sample_next = 8'sd0;
          end else if (out_bit) begin
            last_sample_next = mag;
          end else begin
            last_sample_next = 8'd0 - mag;
          end
        end
      end
      FUNC_LENGTH: begin
        if (length_on && length_left != 7'd0) begin
          length_left_next = length_left - 7'd1;
          if (length_left == 7'd1) begin
            chan_enabled_next = 1'b0;
          end
        end
      end
    endcase
  end

  // result of the current item
  assign res.read_data  = read_data_next;
  assign res.sample_out = last_sample_next;
  assign res.channel_on = chan_enabled_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_reg    <= '0;
      narrow_mode  <= 1'b0;
      freq_ratio   <= '0;
      freq_shift   <= '0;
      length_on    <= 1'b0;
      dac_on       <= 1'b0;
      chan_enabled <= 1'b0;
      length_left  <= '0;
      env_divider  <= '0;
      env_increase <= 1'b0;
      env_initial  <= '0;
      env_volume   <= '0;
      env_active   <= 1'b0;
      last_sample  <= '0;
    end else if (step) begin
      shift_reg    <= shift_reg_next;
      narrow_mode  <= narrow_mode_next;
      freq_ratio   <= freq_ratio_next;
      freq_shift   <= freq_shift_next;
      length_on    <= length_on_next;
      dac_on       <= dac_on_next;
      chan_enabled <= chan_enabled_next;
      length_left  <= length_left_next;
      env_divider  <= env_divider_next;
      env_increase <= env_increase_next;
      env_initial  <= env_initial_next;
      env_volume   <= env_volume_next;
      env_active   <= env_active_next;
      last_sample  <= last_sample_next;
    end
  end

  // restart transfer and the state it must leave behind
  assign restart_xfer = step && item.func == FUNC_WRITE && item.reg_offset == REG_CONTROL &&
                        item.write_value[7];
  assign restart_ok   = shift_reg != 15'd0 && env_active;

  // checks on channel state
  `LNSC_ASSERT_NOW(a_enabled_needs_dac, clk, rst, chan_enabled, dac_on, "channel on with dac off")
  `LNSC_ASSERT_NOW(a_length_range, clk, rst, 1'b1, length_left <= LENGTH_FULL, "length out of range")
  `LNSC_ASSERT_NEXT(a_restart_seeds, clk, rst, restart_xfer, restart_ok, "restart did not seed")

endmodule

// File: hw/rtl/lfsr_noise_sound_channel_core.sv
// top level of the lfsr noise sound channel with output register
// the result is registered and valid in the cycle after the input transfer
// throughput: one item per cycle while results are taken; the result register frees when taken
// in_ready falls only while a result waits and out_ready is low
// reset: synchronous active high, clears all channel state and the result valid
`include "lfsr_noise_sound_channel_core_macros.svh"

module lfsr_noise_sound_channel_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        func,
  input  logic [2:0]        reg_offset,
  input  logic [7:0]        write_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        read_data,
  output logic signed [7:0] sample_out,
  output logic              channel_on
);
  import lnsc_pkg::*;

  item_t   item;
  result_t res;
  result_t res_q;
  logic    in_xfer;
  logic    nonread_xfer;

  assign item.func        = func_t'(func);
  assign item.reg_offset  = reg_offset;
  assign item.write_value = write_value;

  // accept whenever the result register is free or being drained
  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  lnsc_state u_state (
    .clk  (clk),
    .rst  (rst),
    .step (in_xfer),
    .item (item),
    .res  (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_q <= res;
    end
  end

  assign read_data  = res_q.read_data;
  assign sample_out = res_q.sample_out;
  assign channel_on = res_q.channel_on;

  // transfer of anything but a read
  assign nonread_xfer = in_xfer && func != FUNC_READ;

  // handshake checks
  `LNSC_ASSERT_NEXT(a_xfer_gives_result, clk, rst, in_xfer, out_valid, "transfer gave no result")
  `LNSC_ASSERT_NOW(a_ready_when_empty, clk, rst, !out_valid, in_ready, "stalled with empty output")
  `LNSC_ASSERT_NEXT(a_nonread_zero, clk, rst, nonread_xfer, read_data == 8'd0, "read data on non-read")

endmodule

// File: dv/tb_lfsr_noise_sound_channel_core.sv
// self-checking testbench for the lfsr noise sound channel core
module tb_lfsr_noise_sound_channel_core;
  import lnsc_pkg::*;

  // scoreboard: mirrors the channel state and queues the outputs each transfer should produce
  class noise_scoreboard;
    logic [14:0] lfsr = '0;
    logic        narrow = 1'b0;
    logic [2:0]  ratio = '0;
    logic [3:0]  shift_sel = '0;
    logic        len_on = 1'b0;
    logic        dac = 1'b0;
    logic        enabled = 1'b0;
    logic [6:0]  len_left = '0;
    logic [2:0]  env_div = '0;
    logic        env_inc = 1'b0;
    logic [3:0]  env_init = '0;
    logic [3:0]  env_vol = '0;
    logic        env_act = 1'b0;
    logic [7:0]  last = '0;

    result_t channel_results_due[$];
    int errors = 0;

    task report_mismatch(string what, int got, int want);
      errors++;
      // keep the log readable when the design is badly broken
      if (errors <= 100)
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    // register write with envelope zombie-mode volume adjustment
    function void write_reg(logic [2:0] off, logic [7:0] val);
      logic [2:0] old_div;
      logic       old_inc;
      int         v;
      case (off)
        REG_LENGTH: len_left = LENGTH_FULL - {1'b0, val[5:0]};
        REG_ENVELOPE: begin
          old_div = env_div;
          old_inc = env_inc;
          env_div = val[2:0];
          env_inc = val[3];
          env_init = val[7:4];
          dac = (val[7:3] != 5'd0);
          if (!dac) enabled = 1'b0;
          v = env_vol;
          if (old_div == 3'd0 && env_act) v = v + 1;
          else if (!old_inc) v = v + 2;
          if (old_inc != env_inc) v = 16 - v;
          env_vol = v[3:0];
        end
        REG_POLY: begin
          ratio = val[2:0];
          narrow = val[3];
          shift_sel = val[7:4];
        end
        REG_CONTROL: begin
          len_on = val[6];
          // restart
          if (val[7]) begin
            if (dac) enabled = 1'b1;
            if (len_left == 7'd0) len_left = LENGTH_FULL;
            env_vol = env_init;
            env_act = 1'b1;
            lfsr = narrow ? SEED_NARROW : SEED_WIDE;
          end
        end
        default: ;
      endcase
    endfunction

    function logic [7:0] read_reg(logic [2:0] off);
      case (off)
        REG_ENVELOPE: return {env_init, env_inc, env_div};
        REG_POLY:     return {shift_sel, narrow, ratio};
        REG_CONTROL:  return len_on ? LENGTH_EN_MASK : 8'h00;
        default:      return 8'h00;
      endcase
    endfunction

    // one lfsr step, or silence once the length has expired
    function void noise_step();
      logic       lsb;
      logic [7:0] mag;
      if (len_on && len_left == 7'd0) begin
        enabled = 1'b0;
        last = 8'h00;
      end else begin
        lsb = lfsr[0];
        lfsr = lfsr >> 1;
        if (lsb) lfsr = lfsr ^ (narrow ? XOR_NARROW : XOR_WIDE);
        mag = {1'b0, env_vol, 3'b000};
        last = lsb ? mag : (8'h00 - mag);
        if (!dac) last = 8'h00;
      end
    endfunction

    // an accepted input transfer: advance the mirror and queue its output
    function void step_channel(func_t f, logic [2:0] off, logic [7:0] val);
      result_t r;
      r.read_data = 8'h00;
      case (f)
        FUNC_WRITE: write_reg(off, val);
        FUNC_READ:  r.read_data = read_reg(off);
        FUNC_NOISE: noise_step();
        FUNC_LENGTH: begin
          if (len_on && len_left != 7'd0) begin
            len_left = len_left - 7'd1;
            if (len_left == 7'd0) enabled = 1'b0;
          end
        end
        default: ;
      endcase
      r.sample_out = last;
      r.channel_on = enabled;
      channel_results_due.push_back(r);
    endfunction

    // an accepted output transfer: compare against the oldest queued output
    task compare_output(logic [7:0] rd, logic signed [7:0] smp, logic on);
      result_t w;
      if (channel_results_due.size() == 0) begin
        report_mismatch("unexpected output, sample_out", smp, 0);
      end else begin
        w = channel_results_due.pop_front();
        if (rd !== w.read_data) report_mismatch("read_data", rd, w.read_data);
        if (smp !== w.sample_out) report_mismatch("sample_out", smp, w.sample_out);
        if (on !== w.channel_on) report_mismatch("channel_on", on, w.channel_on);
      end
    endtask

    function int pending();
      return channel_results_due.size();
    endfunction
  endclass

  localparam int ItemsPerPhase = 300;
  // offset with no register behind it
  localparam logic [2:0] RegSpare = 3'd6;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        func;
  logic [2:0]        reg_offset;
  logic [7:0]        write_value;
  logic              out_valid;
  logic              out_ready;
  logic [7:0]        read_data;
  logic signed [7:0] sample_out;
  logic              channel_on;

  noise_scoreboard sb;
  int in_count = 0;
  int sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  lfsr_noise_sound_channel_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .reg_offset (reg_offset),
    .write_value(write_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_data  (read_data),
    .sample_out (sample_out),
    .channel_on (channel_on)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // transfer monitor: outputs are checked before the new input is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        sb.compare_output(read_data, sample_out, channel_on);
      if (in_valid && in_ready) begin
        sb.step_channel(func_t'(func), reg_offset, write_value);
        in_count++;
      end
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready = 1'b0;
        hold_cycles--;
      end else begin
        out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // offer one item and wait for its transfer; called at a falling edge
  task automatic send_item(func_t f, logic [2:0] off, logic [7:0] val);
    int n;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    func = f;
    reg_offset = off;
    write_value = val;
    n = in_count;
    do @(negedge clk); while (in_count == n);
    sent++;
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // tick with random don't-care fields
  task automatic send_tick(func_t f);
    send_item(f, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
  endtask

  task automatic send_random_item();
    func_t f;
    f = func_t'($urandom_range(0, 3));
    send_item(f, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
  endtask

  // channel setup with restart, then a run of ticks and register accesses
  task automatic run_burst();
    logic [7:0] len_val;
    int n;
    int k;
    if ($urandom_range(0, 9) < 8) begin
      if ($urandom_range(0, 9) == 0)
        send_item(FUNC_WRITE, REG_ENVELOPE, 8'($urandom_range(0, 7)));
      else
        send_item(FUNC_WRITE, REG_ENVELOPE, 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) < 8)
      send_item(FUNC_WRITE, REG_POLY, 8'($urandom_range(0, 255)));
    // short lengths half the time so that expiry is reached
    len_val = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 1) == 1) len_val[5:0] = 6'($urandom_range(56, 63));
    send_item(FUNC_WRITE, REG_LENGTH, len_val);
    send_item(FUNC_WRITE, REG_CONTROL, {1'b1, 7'($urandom_range(0, 127))});
    n = $urandom_range(8, 40);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 50) send_tick(FUNC_NOISE);
      else if (k < 75) send_tick(FUNC_LENGTH);
      else if (k < 90) send_item(FUNC_READ, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      else send_item(FUNC_WRITE, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    sb = new;
    rst = 1'b1;
    in_valid = 1'b0;
    func = FUNC_WRITE;
    reg_offset = REG_LENGTH;
    write_value = 8'h00;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // directed: tick from reset, full-volume wide restart, length expiry
    send_item(FUNC_NOISE, REG_LENGTH, 8'h00);
    send_item(FUNC_WRITE, REG_ENVELOPE, 8'hF8);
    send_item(FUNC_WRITE, REG_POLY, 8'h00);
    send_item(FUNC_WRITE, REG_LENGTH, 8'h3F);
    send_item(FUNC_WRITE, REG_CONTROL, 8'hC0);
    repeat (3) send_item(FUNC_NOISE, REG_LENGTH, 8'hFF);
    send_item(FUNC_LENGTH, REG_LENGTH, 8'h00);
    send_item(FUNC_NOISE, REG_LENGTH, 8'h00);
    send_item(FUNC_LENGTH, REG_LENGTH, 8'h00);
    // restart with zero length reloads it, then narrow mode seeding
    send_item(FUNC_WRITE, REG_CONTROL, 8'h80);
    send_item(FUNC_WRITE, REG_POLY, 8'hFF);
    send_item(FUNC_WRITE, REG_CONTROL, 8'h80);
    repeat (2) send_item(FUNC_NOISE, REG_LENGTH, 8'h00);
    // dac off, zombie adjustments, tick while disabled
    send_item(FUNC_WRITE, REG_ENVELOPE, 8'h00);
    send_item(FUNC_NOISE, REG_LENGTH, 8'h00);
    send_item(FUNC_WRITE, REG_ENVELOPE, 8'h07);
    send_item(FUNC_WRITE, REG_ENVELOPE, 8'h08);
    // unused offsets and readback
    send_item(FUNC_WRITE, RegSpare, 8'hFF);
    for (int i = 0; i < 8; i++) send_item(FUNC_READ, 3'(i), 8'hFF);
    wait_drained();

    // random phases: no idling, sender idle, receiver stalls, both
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; hold_cycles = 300; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      while (sent < ItemsPerPhase * (p + 1) + 30) begin
        if ($urandom_range(0, 99) < 70) run_burst();
        else send_random_item();
      end
      // sender pauses until the channel has drained
      wait_drained();
    end

    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run limit
  initial begin
    #(400_000 * 8);
    $display("== FAIL ==");
    $finish;
  end
endmodule
